// ===== rtl/frame_energy_voice_detector_macros.svh =====
// Assertion macros shared by the frame energy voice detector RTL.
`ifndef FRAME_ENERGY_VOICE_DETECTOR_MACROS_SVH
`define FRAME_ENERGY_VOICE_DETECTOR_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define FEVD_ASSERT_NOW(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define FEVD_ASSERT_NEXT(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fevd_pkg.sv =====
// Types and constants of the frame energy voice detector.
package fevd_pkg;

  // Frame and datapath sizes
  localparam int MAX_FRAME = 1024;
  localparam int SAMPLE_W  = 16;
  localparam int MAG_W     = SAMPLE_W + 1;
  localparam int THR_W     = 15;
  localparam int TRIG_W    = 8;
  localparam int RUN_W     = 8;
  localparam int COUNT_W   = $clog2(MAX_FRAME + 1);
  localparam int SUM_W     = 2 * SAMPLE_W - 1 + $clog2(MAX_FRAME) + 1;
  localparam int MUL_A_W   = 2 * THR_W;
  localparam int MUL_B_W   = (MAG_W > COUNT_W) ? MAG_W : COUNT_W;
  localparam int MUL_W     = MUL_A_W + MUL_B_W;

  // Stream and configuration widths
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RMS_THRESHOLD  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_FRAMES = CFG_IDX_W'(1);

  // Reset values of the registers
  localparam logic [THR_W-1:0]  RMS_THRESHOLD_RST  = THR_W'(500);
  localparam logic [TRIG_W-1:0] TRIGGER_FRAMES_RST = TRIG_W'(3);

  // Request kinds carried on s_tuser
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_THRSQ,
    ST_LIMIT,
    ST_DECIDE
  } fevd_state_t;

endpackage

// ===== rtl/frame_energy_voice_detector.sv =====
// Frame energy voice detector: top level with sequencer and shared multiplier.
//
// Takes one signed 16-bit sample per request (s_tdata), with s_tlast marking the
// last sample of a frame and s_tuser = 1 marking a clear request. A mid-frame
// sample goes through accept, square and accumulate; a frame-end sample also
// takes the square of the threshold, the limit product and the decision; the
// decision waits while the previous result still sits in the output register.
// The steps are set by the single 30x17 multiplier, reused for the sample square,
// the threshold square and the threshold^2 * count limit. A clear request is
// taken while idle and gives no result. The RMS test is exact: energy sum >
// threshold^2 * count. There is no clearing pass after reset.
`include "frame_energy_voice_detector_macros.svh"

module frame_energy_voice_detector (
  input  logic                                 clk,
  input  logic                                 rst,
  // Sample stream
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [fevd_pkg::IN_DATA_W-1:0]       s_tdata,   // [15:0] sample
  input  logic                                 s_tuser,   // [0] op
  input  logic                                 s_tlast,
  // Frame result stream
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [0] above_threshold, [1] voice_start, [9:2] loud_run, [10] active,
  // [11] frame_too_long, [15:12] zero
  output logic [fevd_pkg::OUT_DATA_W-1:0]      m_tdata,
  // Configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [fevd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fevd_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import fevd_pkg::*;

  fevd_state_t state, state_next;

  logic [THR_W-1:0]   rms_threshold;
  logic [TRIG_W-1:0]  trigger_frames;
  logic [SUM_W-1:0]   energy_sum;
  logic [COUNT_W-1:0] sample_count;
  logic               overflow_seen;
  logic [RUN_W-1:0]   run_count;
  logic               trigger_latch;
  logic [MAG_W-1:0]   mag;
  logic               last_flag;
  logic [SUM_W-1:0]   prod;

  logic               in_accept;
  logic               decide_go;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_W-1:0]   mul_full;
  logic               loud;
  logic [RUN_W-1:0]   run_next;
  logic               start;
  logic [MAG_W-1:0]   mag_in;
  logic [THR_W-1:0]   cfg_thr;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_accept = s_tvalid && s_tready;
  assign decide_go = (state == ST_DECIDE) && (!m_tvalid || m_tready);

  // Magnitude of the incoming sample
  always_comb begin
    if (s_tdata[SAMPLE_W-1]) begin
      mag_in = (MAG_W'(1) << SAMPLE_W) - {1'b0, s_tdata[SAMPLE_W-1:0]};
    end else begin
      mag_in = {1'b0, s_tdata[SAMPLE_W-1:0]};
    end
  end

  // Route operands to the shared multiplier
  always_comb begin
    unique case (state)
      ST_SQUARE: begin
        mul_a = MUL_A_W'(mag);
        mul_b = MUL_B_W'(mag);
      end
      ST_THRSQ: begin
        mul_a = MUL_A_W'(rms_threshold);
        mul_b = MUL_B_W'(rms_threshold);
      end
      ST_LIMIT: begin
        mul_a = prod[MUL_A_W-1:0];
        mul_b = MUL_B_W'(sample_count);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  // Frame decision
  assign loud     = energy_sum > prod;
  assign run_next = loud ? ((run_count == '1) ? run_count : run_count + RUN_W'(1))
                         : '0;
  assign start    = loud && (run_next >= trigger_frames) && !trigger_latch;

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept && s_tuser == OP_SAMPLE) begin
          state_next = ST_SQUARE;
        end
      end
      ST_SQUARE: state_next = ST_ACCUM;
      ST_ACCUM:  state_next = last_flag ? ST_THRSQ : ST_IDLE;
      ST_THRSQ:  state_next = ST_LIMIT;
      ST_LIMIT:  state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (decide_go) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Configuration registers; drop a zero threshold
  assign cfg_thr = cfg_data[THR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      rms_threshold  <= RMS_THRESHOLD_RST;
      trigger_frames <= TRIGGER_FRAMES_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_RMS_THRESHOLD && cfg_thr != '0) begin
        rms_threshold <= cfg_thr;
      end
      if (cfg_index == REG_TRIGGER_FRAMES) begin
        trigger_frames <= cfg_data[TRIG_W-1:0];
      end
    end
  end

  // Hold the accepted sample
  always_ff @(posedge clk) begin
    if (in_accept) begin
      mag       <= mag_in;
      last_flag <= s_tlast;
    end
  end

  // Register the multiplier output
  always_ff @(posedge clk) begin
    if (state == ST_SQUARE || state == ST_THRSQ || state == ST_LIMIT) begin
      prod <= mul_full[SUM_W-1:0];
    end
  end

  // Frame accumulator, run counter and trigger latch
  always_ff @(posedge clk) begin
    if (rst) begin
      energy_sum    <= '0;
      sample_count  <= '0;
      overflow_seen <= 1'b0;
      run_count     <= '0;
      trigger_latch <= 1'b0;
    end else if (in_accept && s_tuser == OP_CLEAR) begin
      energy_sum    <= '0;
      sample_count  <= '0;
      overflow_seen <= 1'b0;
      run_count     <= '0;
      trigger_latch <= 1'b0;
    end else if (state == ST_ACCUM) begin
      if (sample_count < COUNT_W'(MAX_FRAME)) begin
        energy_sum   <= energy_sum + prod;
        sample_count <= sample_count + COUNT_W'(1);
      end else begin
        overflow_seen <= 1'b1;
      end
    end else if (decide_go) begin
      run_count     <= run_next;
      trigger_latch <= trigger_latch || start;
      energy_sum    <= '0;
      sample_count  <= '0;
      overflow_seen <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (decide_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (decide_go) begin
      m_tdata <= {4'b0000, overflow_seen, trigger_latch || start, run_next, start, loud};
    end
  end

  // Checks
  `FEVD_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, sample_count <= COUNT_W'(MAX_FRAME),
    "sample count passed the frame limit")
  `FEVD_ASSERT_NEXT(a_clear_item, clk, rst, in_accept && s_tuser == OP_CLEAR,
    sample_count == '0 && run_count == '0 && !trigger_latch && energy_sum == '0,
    "clear request left state behind")
  `FEVD_ASSERT_NEXT(a_frame_cleared, clk, rst, decide_go,
    sample_count == '0 && energy_sum == '0 && !overflow_seen && m_tvalid,
    "frame end did not clear the accumulator or load the result")
  `FEVD_ASSERT_NOW(a_start_active, clk, rst, m_tvalid && m_tdata[1],
    m_tdata[10] && m_tdata[0], "voice start without a loud frame and set latch")

endmodule
